/* rtl/core/adcsa_pkg.sv */
// ----------------------------------------------------------------------------
// adcsa_pkg
// Shared types and constants for the scan accumulator with SPI frame output.
// ----------------------------------------------------------------------------
`default_nettype none

package adcsa_pkg;

	localparam int NUM_CHANNELS  = 7;
	localparam int TIMEOUT_TICKS = 2;
	localparam int FRAME_BYTES   = 2 * NUM_CHANNELS;

	localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int PTR_W  = $clog2(FRAME_BYTES + 2);
	localparam int TICK_W = 2;
	localparam int SCAN_W = 7;
	localparam int SUM_W  = 16;
	localparam int ADC_W  = 10;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// register byte offsets
	localparam logic [APB_AW-1:0] REG_SCANS_PER_RUN = 3'd0;
	localparam logic [SCAN_W-1:0] SCANS_RESET       = 7'd49;

	// action codes
	localparam logic [1:0] ACT_CONV = 2'd0;
	localparam logic [1:0] ACT_SPI  = 2'd1;
	localparam logic [1:0] ACT_TICK = 2'd2;

	// logical channel to converter input
	localparam logic [2:0] MUX_OF_CH [8] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd6, 3'd7, 3'd5};

	typedef struct packed {
		logic [1:0]       action;
		logic [ADC_W-1:0] adc_value;
	} in_item_t;

	typedef struct packed {
		logic       tx_load;
		logic [7:0] tx_byte;
		logic       adc_start;
		logic [2:0] adc_mux;
		logic       frame_done;
		logic       sampling;
	} out_item_t;

endpackage

`default_nettype wire

/* rtl/core/adc_scan_accumulate_spi_frame.sv */
// ----------------------------------------------------------------------------
// adc_scan_accumulate_spi_frame
// Seven-channel scan accumulator that serves its sums as an SPI frame.
// Order: a beat is held in the input register, and its result is written to
//   the result register, which drives the output channel directly.
// Throughput: one beat per cycle unless the output stalls; one add lane per
//   channel and the frame byte select sit between the input and result registers.
// Reset: arst_n clears sums, counters and handshake state at once; the block
//   comes up serving and scans_per_run reads 49.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_scan_accumulate_spi_frame (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// input channel
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire adcsa_pkg::in_item_t                   in_item,
	// output channel
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output adcsa_pkg::out_item_t                       out_item,
	// configuration port
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [adcsa_pkg::APB_AW-1:0]          paddr,
	input  wire logic [adcsa_pkg::APB_DW-1:0]          pwdata,
	output logic [adcsa_pkg::APB_DW-1:0]               prdata,
	output logic                                       pready
);
	import adcsa_pkg::*;

	// input register
	logic     s1_valid;
	in_item_t s1_item;

	// result register
	logic      out_valid_q;
	out_item_t out_item_q;

	// block state
	logic [SUM_W-1:0]  sums_q [NUM_CHANNELS];
	logic [CH_W-1:0]   ch_idx_q;
	logic [SCAN_W-1:0] scan_cnt_q;
	logic [PTR_W-1:0]  byte_ptr_q;
	logic [TICK_W-1:0] idle_q;
	logic              run_q;
	logic [SCAN_W-1:0] scans_per_run_q;

	// next state from the working stage
	logic [SUM_W-1:0]  sums_d [NUM_CHANNELS];
	logic [CH_W-1:0]   ch_idx_d;
	logic [SCAN_W-1:0] scan_cnt_d;
	logic [PTR_W-1:0]  byte_ptr_d;
	logic [TICK_W-1:0] idle_d;
	logic              run_d;
	out_item_t         res;

	logic out_ready;
	logic advance;
	logic cfg_wr;

	localparam logic [PTR_W-1:0]  PTR_END = PTR_W'(FRAME_BYTES);
	localparam logic [TICK_W-1:0] T_LIM   = TICK_W'(TIMEOUT_TICKS);

	// Result register takes a beat when it is empty or being drained.
	assign out_ready = !out_valid_q || !out_stall;
	assign advance   = s1_valid && out_ready;
	assign in_stall  = s1_valid && !out_ready;

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// --------------------------------------------------------------------
	// Configuration: single register at word 0, written on the access phase.
	// --------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SCANS_PER_RUN[2]);

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_SCANS_PER_RUN[2]) begin
			prdata = APB_DW'(scans_per_run_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scans_per_run_q <= SCANS_RESET;
		end else if (cfg_wr) begin
			scans_per_run_q <= pwdata[SCAN_W-1:0];
		end
	end

	// --------------------------------------------------------------------
	// Input register: load whenever nothing holds it back.
	// --------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (!in_stall) begin
			s1_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			s1_item <= in_item;
		end
	end

	// --------------------------------------------------------------------
	// Working stage: one add lane per channel plus the frame byte select.
	// --------------------------------------------------------------------
	always_comb begin
		logic [CH_W-1:0]   ch;
		logic [CH_W:0]     nxt_ch;
		logic [SCAN_W-1:0] sc_inc;
		logic [SCAN_W-1:0] limit;
		logic [TICK_W-1:0] it;
		logic [7:0]        ptr_byte;
		logic [CH_W-1:0]   hi_sel;

		ch       = (32'(ch_idx_q) >= NUM_CHANNELS) ? '0 : ch_idx_q;
		nxt_ch   = {1'b0, ch} + 1'b1;
		sc_inc   = scan_cnt_q + 1'b1;
		limit    = (scans_per_run_q == '0) ? SCAN_W'(1) : scans_per_run_q;
		it       = idle_q;
		ptr_byte = '0;
		hi_sel   = byte_ptr_q[PTR_W-1:1];

		// frame byte at the pointer, zero past the end
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			if (byte_ptr_q < PTR_END && hi_sel == CH_W'(i)) begin
				ptr_byte = byte_ptr_q[0] ? sums_q[i][15:8] : sums_q[i][7:0];
			end
		end

		for (int i = 0; i < NUM_CHANNELS; i++) begin
			sums_d[i] = sums_q[i];
		end
		ch_idx_d   = ch_idx_q;
		scan_cnt_d = scan_cnt_q;
		byte_ptr_d = byte_ptr_q;
		idle_d     = idle_q;
		run_d      = run_q;
		res        = '0;

		if (s1_item.action == ACT_CONV && run_q) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				if (ch == CH_W'(i)) begin
					sums_d[i] = sums_q[i] + SUM_W'(s1_item.adc_value);
				end
			end
			if (32'(nxt_ch) < NUM_CHANNELS) begin
				ch_idx_d      = nxt_ch[CH_W-1:0];
				res.adc_start = 1'b1;
				res.adc_mux   = MUX_OF_CH[nxt_ch[CH_W-1:0]];
			end else begin
				ch_idx_d   = '0;
				scan_cnt_d = sc_inc;
				if (sc_inc >= limit) begin
					// run over: reload the frame from byte 0
					run_d       = 1'b0;
					res.tx_load = 1'b1;
					res.tx_byte = sums_d[0][7:0];
					byte_ptr_d  = PTR_W'(1);
				end else begin
					res.adc_start = 1'b1;
					res.adc_mux   = MUX_OF_CH[0];
				end
			end
		end else if (s1_item.action == ACT_SPI && !run_q) begin
			res.tx_load = 1'b1;
			res.tx_byte = ptr_byte;
			idle_d      = '0;
			if (byte_ptr_q == PTR_END) begin
				// frame complete: clear sums and start sampling
				res.frame_done = 1'b1;
				idle_d         = T_LIM;
				for (int i = 0; i < NUM_CHANNELS; i++) begin
					sums_d[i] = '0;
				end
				run_d         = 1'b1;
				scan_cnt_d    = '0;
				ch_idx_d      = '0;
				res.adc_start = 1'b1;
				res.adc_mux   = MUX_OF_CH[0];
			end
			if (byte_ptr_q <= PTR_END) begin
				byte_ptr_d = byte_ptr_q + 1'b1;
			end
		end else if (s1_item.action == ACT_TICK && !run_q) begin
			if (it < T_LIM) begin
				it = it + 1'b1;
			end
			idle_d = it;
			if (it == T_LIM) begin
				// link idle: restart the frame
				res.tx_load = 1'b1;
				res.tx_byte = sums_q[0][7:0];
				byte_ptr_d  = PTR_W'(1);
			end
		end

		res.sampling = run_d;
	end

	// --------------------------------------------------------------------
	// State and result registers: advance only when a beat is held and the result register can take it.
	// --------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				sums_q[i] <= '0;
			end
			ch_idx_q   <= '0;
			scan_cnt_q <= '0;
			byte_ptr_q <= '0;
			idle_q     <= '0;
			run_q      <= 1'b0;
		end else if (advance) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				sums_q[i] <= sums_d[i];
			end
			ch_idx_q   <= ch_idx_d;
			scan_cnt_q <= scan_cnt_d;
			byte_ptr_q <= byte_ptr_d;
			idle_q     <= idle_d;
			run_q      <= run_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q <= res;
		end
	end

`ifndef NO_ASSERTIONS
	a_done_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_item_q.frame_done |-> out_item_q.sampling && out_item_q.adc_start)
		else $error("frame end without run start");

	a_start_only_sampling: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_item_q.adc_start |-> out_item_q.sampling)
		else $error("conversion started while serving");

	a_load_while_sampling: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_item_q.tx_load && out_item_q.sampling |-> out_item_q.frame_done)
		else $error("byte loaded during a run");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_ptr_q <= PTR_END + 1'b1)
		else $error("byte pointer past saturation");

	a_stall_holds_stage: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> s1_valid && $stable(s1_item))
		else $error("input register lost a stalled beat");
`endif

endmodule

`default_nettype wire

/* verif/adc_scan_accumulate_spi_frame_tb.sv */
// ----------------------------------------------------------------------------
// adc_scan_accumulate_spi_frame_tb
// Self-checking bench for the scan accumulator and its SPI frame. A model of
// the channel sums, the scan counter and the frame pointer runs alongside the
// block and predicts one output beat per input beat. Each test task below but
// the directed one sets the run length over the APB port, picks an idling
// pattern and then drives directed or random events: conversions, SPI bytes,
// timer ticks and unused codes.
// ----------------------------------------------------------------------------
module adc_scan_accumulate_spi_frame_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import adcsa_pkg::*;

	// Code 3 has no meaning in the block; keep a name for it here.
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int unsigned ADC_MAX = (1 << ADC_W) - 1;
	localparam int unsigned REPORT_CAP = 40;

	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	in_item_t            in_item   = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	out_item_t           out_item;
	logic                psel      = 1'b0;
	logic                penable   = 1'b0;
	logic                pwrite    = 1'b0;
	logic [APB_AW-1:0]   paddr     = '0;
	logic [APB_DW-1:0]   pwdata    = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	adc_scan_accumulate_spi_frame dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// 8 ns period: four high, four low.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Shadow of the block's state. It starts at the reset values and is only
	// advanced when a beat is accepted or a register is written.
	// ------------------------------------------------------------------------
	logic [SUM_W-1:0]  chan_sums [NUM_CHANNELS] = '{default: '0};
	logic [CH_W-1:0]   chan_idx    = '0;
	logic [SCAN_W-1:0] scans_done  = '0;
	logic [PTR_W-1:0]  frame_ptr   = '0;
	logic [TICK_W-1:0] idle_ticks  = '0;
	logic              run_active  = 1'b0;
	logic [SCAN_W-1:0] scans_limit = SCANS_RESET;

	// Output beats the block still owes, oldest first.
	out_item_t owed_beats [$];

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned mismatch_count = 0;
	int unsigned beat_count     = 0;

	// Byte k of the little-endian frame of sums; zero past its end.
	function automatic logic [7:0] sum_frame_byte(input int unsigned k);
		logic [SUM_W-1:0] s;
		if (k >= FRAME_BYTES) begin
			return 8'h00;
		end
		s = chan_sums[k >> 1];
		return (k & 1) ? s[15:8] : s[7:0];
	endfunction

	// Advance the shadow state by one accepted beat and return the output
	// beat that the block must produce for it.
	function automatic out_item_t accumulate_and_serve(input in_item_t beat);
		out_item_t   r;
		int unsigned ch;
		int unsigned nxt;
		int unsigned limit;
		int unsigned p;
		r = '0;
		case (beat.action)
			ACT_CONV: begin
				if (run_active) begin
					ch = (chan_idx >= NUM_CHANNELS) ? 0 : chan_idx;
					chan_sums[ch] = chan_sums[ch] + beat.adc_value;
					nxt = ch + 1;
					if (nxt < NUM_CHANNELS) begin
						chan_idx    = CH_W'(nxt);
						r.adc_start = 1'b1;
						r.adc_mux   = MUX_OF_CH[nxt];
					end else begin
						// A zero limit still ends the run after one scan.
						limit      = (scans_limit == 0) ? 1 : scans_limit;
						chan_idx   = '0;
						scans_done = scans_done + 1'b1;
						if (scans_done >= limit) begin
							run_active = 1'b0;
							r.tx_load  = 1'b1;
							r.tx_byte  = sum_frame_byte(0);
							frame_ptr  = PTR_W'(1);
						end else begin
							r.adc_start = 1'b1;
							r.adc_mux   = MUX_OF_CH[0];
						end
					end
				end
			end
			ACT_SPI: begin
				if (!run_active) begin
					p          = frame_ptr;
					r.tx_load  = 1'b1;
					r.tx_byte  = sum_frame_byte(p);
					idle_ticks = '0;
					if (p == FRAME_BYTES) begin
						// Frame exchanged: clear the sums and start sampling.
						r.frame_done = 1'b1;
						idle_ticks   = TICK_W'(TIMEOUT_TICKS);
						foreach (chan_sums[i]) begin
							chan_sums[i] = '0;
						end
						run_active  = 1'b1;
						scans_done  = '0;
						chan_idx    = '0;
						r.adc_start = 1'b1;
						r.adc_mux   = MUX_OF_CH[0];
					end
					if (p <= FRAME_BYTES) begin
						frame_ptr = PTR_W'(p + 1);
					end
				end
			end
			ACT_TICK: begin
				if (!run_active) begin
					if (idle_ticks < TIMEOUT_TICKS) begin
						idle_ticks = idle_ticks + 1'b1;
					end
					if (idle_ticks == TIMEOUT_TICKS) begin
						r.tx_load = 1'b1;
						r.tx_byte = sum_frame_byte(0);
						frame_ptr = PTR_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
		r.sampling = run_active;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		mismatch_count++;
		if (mismatch_count <= REPORT_CAP) begin
			$display("[%0t] out beat %0d: %s got 0x%0h, want 0x%0h",
				$realtime, beat_count, what, got, want);
		end
	endtask

	// ------------------------------------------------------------------------
	// Output side. Drive stall at the rising edge; sample at the falling edge
	// so that valid, stall and payload are all settled for the next edge, at
	// which the beat is taken.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	always @(negedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (owed_beats.size() == 0) begin
				report_mismatch("beat with none owed", out_item, 0);
			end else begin
				want = owed_beats.pop_front();
				if (out_item.tx_load !== want.tx_load)
					report_mismatch("tx_load", out_item.tx_load, want.tx_load);
				if (out_item.tx_byte !== want.tx_byte)
					report_mismatch("tx_byte", out_item.tx_byte, want.tx_byte);
				if (out_item.adc_start !== want.adc_start)
					report_mismatch("adc_start", out_item.adc_start, want.adc_start);
				if (out_item.adc_mux !== want.adc_mux)
					report_mismatch("adc_mux", out_item.adc_mux, want.adc_mux);
				if (out_item.frame_done !== want.frame_done)
					report_mismatch("frame_done", out_item.frame_done, want.frame_done);
				if (out_item.sampling !== want.sampling)
					report_mismatch("sampling", out_item.sampling, want.sampling);
			end
			beat_count++;
		end
	end

	// ------------------------------------------------------------------------
	// Input side helpers. All of them are entered and left at a rising edge.
	// ------------------------------------------------------------------------
	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			IDLE_SEND: begin send_idle_pct = 87; recv_stall_pct = 0;  end
			IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 87; end
			default:   begin send_idle_pct = 28; recv_stall_pct = 28; end
		endcase
	endtask

	// Offer one beat and return at the edge that takes it. Valid stays high
	// afterwards, so the next caller either lowers it or offers a new beat.
	task automatic send_beat(input in_item_t beat);
		logic stalled;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do begin
				@(posedge clk);
			end while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_item  <= beat;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		owed_beats.push_back(accumulate_and_serve(beat));
	endtask

	function automatic in_item_t make_beat(input logic [1:0] action,
			input int unsigned value);
		in_item_t b;
		b.action    = action;
		b.adc_value = ADC_W'(value);
		return b;
	endfunction

	// Mostly well-formed traffic for the current phase: conversions while
	// sampling, SPI bytes and ticks while serving, with a little noise.
	function automatic in_item_t pick_beat(input bit high_values);
		in_item_t    b;
		int unsigned roll;
		int unsigned vroll;
		roll  = $urandom_range(0, 99);
		vroll = $urandom_range(0, 99);
		if (run_active) begin
			b.action = (roll < 92) ? ACT_CONV : (roll < 95) ? ACT_SPI :
				(roll < 98) ? ACT_TICK : ACT_UNUSED;
		end else begin
			b.action = (roll < 65) ? ACT_SPI : (roll < 87) ? ACT_TICK :
				(roll < 95) ? ACT_CONV : ACT_UNUSED;
		end
		if (high_values)
			b.adc_value = ADC_W'((vroll < 30) ? ADC_MAX : $urandom_range(1000, ADC_MAX));
		else if (vroll < 12)
			b.adc_value = '0;
		else if (vroll < 24)
			b.adc_value = ADC_W'(ADC_MAX);
		else
			b.adc_value = ADC_W'($urandom_range(0, ADC_MAX));
		return b;
	endfunction

	// Drive random beats until 'count' of them have done something; ignored
	// events ride along but are not counted.
	task automatic run_random(input int unsigned count, input bit high_values);
		in_item_t    b;
		int unsigned handled;
		handled = 0;
		while (handled < count) begin
			b = pick_beat(high_values);
			if ((b.action == ACT_CONV && run_active) ||
					((b.action == ACT_SPI || b.action == ACT_TICK) && !run_active))
				handled++;
			send_beat(b);
		end
	endtask

	// Drop valid and wait for every owed beat, then let the pipe empty out.
	task automatic wait_for_results();
		int unsigned guard;
		guard = 0;
		in_valid <= 1'b0;
		while (owed_beats.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
	endtask

	// APB write: setup cycle, then access until pready.
	task automatic write_scans_per_run(input logic [SCAN_W-1:0] value);
		logic rdy;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_SCANS_PER_RUN;
		pwdata  <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdy = pready;
			@(posedge clk);
		end while (!rdy);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		scans_limit = value;
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Walk the reset state by hand: idle timeout, ignored events while
	// serving, a whole frame, the restart of sampling and ignored events
	// while sampling, with the converter extremes at the end.
	task automatic test_directed_frame();
		set_idling(IDLE_NONE);
		send_beat(make_beat(ACT_TICK, 0));          // first idle tick, no load
		send_beat(make_beat(ACT_CONV, ADC_MAX));    // conversion while serving
		send_beat(make_beat(ACT_UNUSED, ADC_MAX));  // unused code
		send_beat(make_beat(ACT_TICK, 0));          // timeout: reload byte 0
		send_beat(make_beat(ACT_TICK, ADC_MAX));    // still timed out
		for (int i = 0; i < FRAME_BYTES - 1; i++) begin
			send_beat(make_beat(ACT_SPI, i));
		end
		send_beat(make_beat(ACT_SPI, 0));           // past the end: frame done
		send_beat(make_beat(ACT_SPI, 0));           // ignored while sampling
		send_beat(make_beat(ACT_TICK, 0));          // ignored while sampling
		send_beat(make_beat(ACT_UNUSED, 0));
		send_beat(make_beat(ACT_CONV, ADC_MAX));
		send_beat(make_beat(ACT_CONV, 0));
		send_beat(make_beat(ACT_CONV, ADC_MAX));
		wait_for_results();
	endtask

	// A zero run length acts as one scan per run.
	task automatic test_zero_scans();
		write_scans_per_run('0);
		set_idling(IDLE_SEND);
		run_random(70, 1'b0);
		wait_for_results();
	endtask

	task automatic test_single_scan();
		write_scans_per_run(SCAN_W'(1));
		set_idling(IDLE_RECV);
		run_random(70, 1'b0);
		wait_for_results();
	endtask

	task automatic test_short_runs();
		write_scans_per_run(SCAN_W'($urandom_range(2, 6)));
		set_idling(IDLE_BOTH);
		run_random(70, 1'b0);
		wait_for_results();
	endtask

	// Top of the normal range: one full run of 64 scans, with stalls.
	task automatic test_longest_run();
		write_scans_per_run(SCAN_W'(64));
		set_idling(IDLE_NONE);
		run_random(260, 1'b0);
		set_idling(IDLE_RECV);
		run_random(260, 1'b0);
		wait_for_results();
	endtask

	// Past 64 scans of near-full readings the 16-bit sums wrap. Close the
	// current run with one-scan runs of high readings first, so the 66-scan
	// run holds high readings only.
	task automatic test_sum_wrap();
		write_scans_per_run(SCAN_W'(1));
		set_idling(IDLE_BOTH);
		run_random(40, 1'b1);
		wait_for_results();
		write_scans_per_run(SCAN_W'(66));
		run_random(540, 1'b1);
		wait_for_results();
	endtask

	// Largest value the register holds; only a short stretch of it.
	task automatic test_largest_setting();
		write_scans_per_run('1);
		set_idling(IDLE_SEND);
		run_random(40, 1'b0);
		wait_for_results();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_frame();
		test_zero_scans();
		test_single_scan();
		test_short_runs();
		test_longest_run();
		test_sum_wrap();
		test_largest_setting();
		if (owed_beats.size() != 0)
			report_mismatch("beats never delivered", 0, owed_beats.size());
		if (mismatch_count == 0) begin
			$display("adc_scan_accumulate_spi_frame verification clean");
		end else begin
			$display("adc_scan_accumulate_spi_frame verification failed");
		end
		$finish;
	end

	// Hard stop far beyond the slowest correct run.
	initial begin
		#4ms;
		$display("adc_scan_accumulate_spi_frame verification failed");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/adcsa_pkg.sv
rtl/core/adc_scan_accumulate_spi_frame.sv
verif/adc_scan_accumulate_spi_frame_tb.sv
